@@ rtl/core/hsfd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package hsfd_pkg;

	// CRC-8 of each sensor word: polynomial 0x31, seed 0xFF, MSB first
	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	// Scale factors over a full-scale divisor of 65535
	localparam int unsigned TEMP_SCALE  = 17500;
	localparam int unsigned HUM_SCALE   = 10000;
	localparam int unsigned TEMP_OFFSET = 4500;

	localparam int unsigned TEMP_W      = 15;
	localparam int unsigned HUM_W       = 14;
	localparam int unsigned TEMP_PROD_W = 31;
	localparam int unsigned HUM_PROD_W  = 30;

	// Completed frame handed from the frame tracker to the scaler
	typedef struct packed {
		logic        mismatch;
		logic [15:0] temp_raw;
		logic [15:0] hum_raw;
	} frame_res_t;

	// One byte through the CRC-8 register
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/hsfd_frame.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hsfd_frame (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire logic [7:0]         in_byte,
	input  wire logic               in_start,
	output      logic               res_valid,
	input  wire logic               res_ready,
	output      hsfd_pkg::frame_res_t res
);

	typedef enum logic [2:0] {
		POS_T_MSB = 3'd0,
		POS_T_LSB = 3'd1,
		POS_T_CRC = 3'd2,
		POS_H_MSB = 3'd3,
		POS_H_LSB = 3'd4,
		POS_H_CRC = 3'd5
	} pos_t;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;

	pos_t        pos_q;
	logic [7:0]  crc_q;
	logic        mismatch_q;
	logic [15:0] temp_raw_q;
	logic [15:0] hum_raw_q;

	logic        active;
	pos_t        eff_pos;
	logic [7:0]  crc_base;
	logic        mis_base;
	logic        crc_bad;
	logic        final_byte;
	logic        go_s1;

	// Word resolved against the frame state; a start restarts the frame
	always_comb begin
		eff_pos    = start_s1 ? POS_T_MSB : pos_q;
		crc_base   = start_s1 ? hsfd_pkg::CRC_INIT : crc_q;
		mis_base   = start_s1 ? 1'b0 : mismatch_q;
		active     = start_s1 || (pos_q != POS_T_MSB);
		crc_bad    = (crc_base != byte_s1);
		final_byte = valid_s1 && active && (eff_pos == POS_H_CRC);
		go_s1      = !final_byte || res_ready;
	end

	assign in_ready      = !valid_s1 || go_s1;
	assign res_valid     = final_byte;
	assign res.mismatch  = mis_base || crc_bad;
	assign res.temp_raw  = temp_raw_q;
	assign res.hum_raw   = hum_raw_q;

	// Hold the incoming word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= in_byte;
			start_s1 <= in_start;
		end
	end

	// Advance the frame position, CRC and raw words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= POS_T_MSB;
			crc_q      <= hsfd_pkg::CRC_INIT;
			mismatch_q <= 1'b0;
			temp_raw_q <= 16'h0000;
			hum_raw_q  <= 16'h0000;
		end else if (valid_s1 && active && go_s1) begin
			unique case (eff_pos)
				POS_T_MSB: begin
					crc_q      <= hsfd_pkg::crc8_step(crc_base, byte_s1);
					temp_raw_q <= {byte_s1, 8'h00};
					mismatch_q <= mis_base;
					pos_q      <= POS_T_LSB;
				end
				POS_T_LSB: begin
					crc_q      <= hsfd_pkg::crc8_step(crc_base, byte_s1);
					temp_raw_q <= {temp_raw_q[15:8], byte_s1};
					pos_q      <= POS_T_CRC;
				end
				POS_T_CRC: begin
					mismatch_q <= mis_base || crc_bad;
					crc_q      <= hsfd_pkg::CRC_INIT;
					pos_q      <= POS_H_MSB;
				end
				POS_H_MSB: begin
					crc_q     <= hsfd_pkg::crc8_step(crc_base, byte_s1);
					hum_raw_q <= {byte_s1, 8'h00};
					pos_q     <= POS_H_LSB;
				end
				POS_H_LSB: begin
					crc_q     <= hsfd_pkg::crc8_step(crc_base, byte_s1);
					hum_raw_q <= {hum_raw_q[15:8], byte_s1};
					pos_q     <= POS_H_CRC;
				end
				default: begin
					// Last byte: frame goes out, return to idle
					crc_q      <= hsfd_pkg::CRC_INIT;
					mismatch_q <= 1'b0;
					pos_q      <= POS_T_MSB;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/hsfd_scale.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hsfd_scale (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 res_valid,
	output      logic                 res_ready,
	input  wire hsfd_pkg::frame_res_t res,
	output      logic                 out_valid,
	input  wire logic                 out_ready,
	output      logic                 out_status,
	output      logic [hsfd_pkg::TEMP_W-1:0] out_temp,
	output      logic [hsfd_pkg::HUM_W-1:0]  out_hum
);

	localparam int unsigned TP = hsfd_pkg::TEMP_PROD_W;
	localparam int unsigned HP = hsfd_pkg::HUM_PROD_W;
	localparam int unsigned TW = hsfd_pkg::TEMP_W;
	localparam int unsigned HW = hsfd_pkg::HUM_W;

	logic          valid_s2;
	logic          mismatch_s2;
	logic [TP-1:0] temp_prod_s2;
	logic [HP-1:0] hum_prod_s2;
	logic          go_s2;

	logic [TW-1:0] temp_q0;
	logic [TW:0]   temp_y;
	logic [TP:0]   temp_ymul;
	logic [TW-1:0] temp_quot;
	logic [TW-1:0] temp_val;
	logic [HW-1:0] hum_q0;
	logic [HW:0]   hum_y;
	logic [HP:0]   hum_ymul;
	logic [HW-1:0] hum_quot;

	logic          out_valid_q;
	logic          status_q;
	logic [TW-1:0] last_temp_q;
	logic [HW-1:0] last_hum_q;

	assign go_s2     = !out_valid_q || out_ready;
	assign res_ready = !valid_s2 || go_s2;

	// Scale the raw words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (res_ready) begin
			valid_s2 <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			mismatch_s2  <= res.mismatch;
			temp_prod_s2 <= TP'(res.temp_raw) * TP'(hsfd_pkg::TEMP_SCALE);
			hum_prod_s2  <= HP'(res.hum_raw) * HP'(hsfd_pkg::HUM_SCALE);
		end
	end

	// Divide by 65535: quotient is x>>16 or one more; y*65535 = (y<<16) - y
	always_comb begin
		temp_q0   = temp_prod_s2[TP-1:16];
		temp_y    = {1'b0, temp_q0} + (TW+1)'(1);
		temp_ymul = {temp_y, 16'h0000} - (TP+1)'(temp_y);
		temp_quot = temp_q0 + TW'({1'b0, temp_prod_s2} >= temp_ymul);
		temp_val  = temp_quot - TW'(hsfd_pkg::TEMP_OFFSET);

		hum_q0    = hum_prod_s2[HP-1:16];
		hum_y     = {1'b0, hum_q0} + (HW+1)'(1);
		hum_ymul  = {hum_y, 16'h0000} - (HP+1)'(hum_y);
		hum_quot  = hum_q0 + HW'({1'b0, hum_prod_s2} >= hum_ymul);
	end

	// Keep the last good reading and load the result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			status_q    <= 1'b0;
			last_temp_q <= '0;
			last_hum_q  <= '0;
		end else if (go_s2) begin
			out_valid_q <= valid_s2;
			if (valid_s2) begin
				status_q <= mismatch_s2;
				if (!mismatch_s2) begin
					last_temp_q <= temp_val;
					last_hum_q  <= hum_quot;
				end
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = status_q;
	assign out_temp   = last_temp_q;
	assign out_hum    = last_hum_q;

endmodule

`default_nettype wire

@@ rtl/core/humidity_sensor_frame_decoder.sv @@
// The sixth byte of a frame passes the input byte, scale and output word registers.
// Throughput: one byte per cycle; a waiting result stalls input only when the
// next frame end finds both the scale stage and the output word occupied.
// Reset: arst_n clears to idle, CRC seed 0xFF, last good readings zero.
`timescale 1ns / 1ps
`default_nettype none

module humidity_sensor_frame_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic [0:0]  s_tuser,   // [0] frame_start
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [31:0] m_tdata,   // [14:0] temperature, [28:15] humidity, zero above
	output      logic [0:0]  m_tuser    // [0] status
);

	logic                 res_valid;
	logic                 res_ready;
	hsfd_pkg::frame_res_t res;
	logic                 out_status;
	logic [hsfd_pkg::TEMP_W-1:0] out_temp;
	logic [hsfd_pkg::HUM_W-1:0]  out_hum;

	// Track frame bytes and CRC
	hsfd_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.in_start  (s_tuser[0]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Convert and hold the result word
	hsfd_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (out_status),
		.out_temp   (out_temp),
		.out_hum    (out_hum)
	);

	assign m_tdata = {3'b000, out_hum, out_temp};
	assign m_tuser = out_status;

endmodule

`default_nettype wire

@@ rtl/core/hsfd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hsfd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [0:0]  m_tuser
);

	// Stalled result word stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped under stall");

	// Input backs up only behind a stalled result word
	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without a blocked result word");

	// Humidity never exceeds full scale
	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[28:15] <= 14'd10000)
		else $error("humidity out of range");

	// Temperature stays within the sensor span
	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[14:0]) >= -15'sd4500
			&& $signed(m_tdata[14:0]) <= 15'sd13000))
		else $error("temperature out of range");

	// A failed frame repeats the previously reported reading
	a_fail_repeats: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |=> !m_tvalid || m_tuser[0] == 1'b0
			|| m_tdata[28:0] == $past(m_tdata[28:0]) || !$past(m_tvalid))
		else $error("failed frame changed the reported reading");

endmodule

bind humidity_sensor_frame_decoder hsfd_checker u_hsfd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
